/* src/ucpd_pkg.sv */
// ----------------------------------------------------------------------------
// ucpd_pkg: shared types for the UTF-8 code point decoder
// Word operations passed from the classifier to the assembler, queue entry.
// ----------------------------------------------------------------------------
package ucpd_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CP_W        = 31;
	localparam int unsigned CNT_W       = 3;
	localparam int unsigned CONT_BITS   = 6;
	localparam int unsigned MAX_SEQ     = 6;
	localparam int unsigned QUEUE_DEPTH = 2;

	// What the back end does with one classified word
	typedef enum logic [1:0] {
		OP_SINGLE = 2'd0,  // emit data as a one-byte code point
		OP_LEAD   = 2'd1,  // load accumulator with lead payload
		OP_CONT   = 2'd2,  // shift in six bits, sequence still open
		OP_LAST   = 2'd3   // shift in six bits and emit
	} ucpd_op_t;

	typedef struct packed {
		ucpd_op_t            op;
		logic [BYTE_W-1:0]   data;
		logic [CNT_W-1:0]    cnt;
	} ucpd_entry_t;

endpackage

/* src/utf8_code_point_decoder_core.sv */
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_core: streaming six-byte UTF-8 decoder
// Takes one byte word per cycle while the queue has room, emits code point and byte count words.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+------------------
//  in      | in_valid, in_ready, in_byte      | sink      | one raw text byte
//  out     | out_valid, out_ready,            | source    | one code point
//          | code_point, byte_count           |           | and its length
//
// One byte word is taken every cycle while the queue has room; the result
// of its last byte passes the queue and then the output register (classify,
// queue, assemble). Throughput: one byte per cycle unless the output stalls,
// set by the combinational classifier and the one-entry-per-cycle assembler.
// Reset (arst_n low) closes any open sequence and empties queue and output.
// An output stall stops only the assembler when it holds an emitting word;
// the classifier keeps accepting until the queue fills.
module utf8_code_point_decoder_core #(
	parameter int unsigned QUEUE_DEPTH = ucpd_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ucpd_pkg::BYTE_W-1:0]   in_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ucpd_pkg::CP_W-1:0]     code_point,
	output logic [ucpd_pkg::CNT_W-1:0]    byte_count
);
	import ucpd_pkg::*;

	ucpd_entry_t front_entry;  // classified word from the front end
	ucpd_entry_t back_entry;   // head of queue
	logic        take;         // input word accepted this cycle
	logic        q_not_full;
	logic        q_not_empty;
	logic        q_pop;

	assign in_ready = q_not_full;
	assign take     = in_valid && q_not_full;

	// Front: sequence tracking and byte classification
	ucpd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (in_byte),
		.entry   (front_entry)
	);

	// Queue: lets front and back stall independently
	ucpd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (front_entry),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.pop_data  (back_entry),
		.not_empty (q_not_empty)
	);

	// Back: accumulate six-bit groups, register results
	ucpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (q_not_empty),
		.entry       (back_entry),
		.entry_pop   (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.byte_count  (byte_count)
	);

endmodule

/* src/ucpd_front.sv */
// ----------------------------------------------------------------------------
// ucpd_front: byte classifier
// Tracks sequence position and turns each byte into a queue entry.
// ----------------------------------------------------------------------------
module ucpd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [ucpd_pkg::BYTE_W-1:0] in_byte,
	output ucpd_pkg::ucpd_entry_t     entry
);
	import ucpd_pkg::*;

	logic [CNT_W-1:0] bytes_left_q;
	logic [CNT_W-1:0] seq_len_q;
	logic [CNT_W-1:0] lead_n;     // leading ones, saturated at 7
	logic [BYTE_W-1:0] lead_mask;

	always_comb begin
		unique casez (in_byte)
			8'b0???????: lead_n = 3'd0;
			8'b10??????: lead_n = 3'd1;
			8'b110?????: lead_n = 3'd2;
			8'b1110????: lead_n = 3'd3;
			8'b11110???: lead_n = 3'd4;
			8'b111110??: lead_n = 3'd5;
			8'b1111110?: lead_n = 3'd6;
			default:     lead_n = 3'd7;
		endcase
	end

	assign lead_mask = 8'h7F >> lead_n;

	always_comb begin
		entry.cnt = seq_len_q;
		if (bytes_left_q != '0) begin
			entry.op   = (bytes_left_q == CNT_W'(1)) ? OP_LAST : OP_CONT;
			entry.data = {2'b00, in_byte[CONT_BITS-1:0]};
		end else if (lead_n == 3'd1) begin
			// stray continuation byte
			entry.op   = OP_SINGLE;
			entry.data = {2'b00, in_byte[CONT_BITS-1:0]};
		end else if (lead_n == 3'd0 || lead_n > CNT_W'(MAX_SEQ)) begin
			// ASCII, or 0xFE / 0xFF passed through raw
			entry.op   = OP_SINGLE;
			entry.data = in_byte;
		end else begin
			entry.op   = OP_LEAD;
			entry.data = in_byte & lead_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			seq_len_q    <= '0;
		end else if (take) begin
			if (bytes_left_q != '0) begin
				bytes_left_q <= bytes_left_q - CNT_W'(1);
			end else if (entry.op == OP_LEAD) begin
				bytes_left_q <= lead_n - CNT_W'(1);
				seq_len_q    <= lead_n;
			end
		end
	end

endmodule

/* src/ucpd_fifo.sv */
// ----------------------------------------------------------------------------
// ucpd_fifo: short register queue
// Decouples the classifier from the assembler.
// ----------------------------------------------------------------------------
module ucpd_fifo #(
	parameter int unsigned DEPTH = ucpd_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ucpd_pkg::ucpd_entry_t push_data,
	output logic                  not_full,
	input  logic                  pop,
	output ucpd_pkg::ucpd_entry_t pop_data,
	output logic                  not_empty
);
	import ucpd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ucpd_entry_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign not_full  = (count_q != CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* src/ucpd_back.sv */
// ----------------------------------------------------------------------------
// ucpd_back: code point assembler
// Accumulates payload bits and holds the result word in an output register.
// ----------------------------------------------------------------------------
module ucpd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          entry_valid,
	input  ucpd_pkg::ucpd_entry_t         entry,
	output logic                          entry_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ucpd_pkg::CP_W-1:0]     code_point,
	output logic [ucpd_pkg::CNT_W-1:0]    byte_count
);
	import ucpd_pkg::*;

	logic [CP_W-1:0]  acc_q;
	logic [CP_W-1:0]  shifted;
	logic             out_valid_q;
	logic [CP_W-1:0]  code_point_q;
	logic [CNT_W-1:0] byte_count_q;
	logic             emits;
	logic             out_free;

	assign shifted   = {acc_q[CP_W-CONT_BITS-1:0], entry.data[CONT_BITS-1:0]};
	assign emits     = (entry.op == OP_SINGLE) || (entry.op == OP_LAST);
	assign out_free  = !out_valid_q || out_ready;
	assign entry_pop = entry_valid && (!emits || out_free);

	assign out_valid  = out_valid_q;
	assign code_point = code_point_q;
	assign byte_count = byte_count_q;

	always_ff @(posedge clk) begin
		if (entry_pop) begin
			unique case (entry.op)
				OP_SINGLE: begin
					code_point_q <= CP_W'(entry.data);
					byte_count_q <= CNT_W'(1);
				end
				OP_LEAD: acc_q <= CP_W'(entry.data);
				OP_CONT: acc_q <= shifted;
				OP_LAST: begin
					code_point_q <= shifted;
					byte_count_q <= entry.cnt;
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (entry_pop && emits) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: regression bench for utf8_code_point_decoder_core
// Streams directed and random UTF-8 text through the decoder and predicts
// each code point word in the bench. Bursty sender, patterned receiver stalls.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ucpd_pkg::*;

	localparam int unsigned TEXT_LEN    = 1550;
	localparam int unsigned STALL_LIMIT = 5000;   // cycles with no handshake
	localparam int unsigned DRAIN_WAIT  = 16;     // tail after the last word
	localparam int unsigned PRINT_CAP   = 100;

	localparam logic [BYTE_W-1:0] LOW6  = 8'h3F;
	localparam logic [BYTE_W-1:0] CONT  = 8'h80;  // 10xxxxxx marker
	localparam logic [BYTE_W-1:0] BYTE_FE = 8'hFE;
	localparam logic [BYTE_W-1:0] BYTE_FF = 8'hFF;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [CNT_W-1:0] byte_count;
	} cp_word_t;

	// receiver behavior, re-drawn at random intervals
	typedef enum logic [1:0] {
		RDY_ALWAYS,   // never stalls
		RDY_COIN,     // fair coin each cycle
		RDY_PATTERN,  // rotating 16-bit mask
		RDY_SPARSE    // randomly ready, mostly stalled
	} ready_mode_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [BYTE_W-1:0]   in_byte   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CP_W-1:0]     code_point;
	logic [CNT_W-1:0]    byte_count;

	utf8_code_point_decoder_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_point (code_point),
		.byte_count (byte_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Decoder shadow: open sequence state kept in bench terms
	// ------------------------------------------------------------------------
	logic [CNT_W-1:0]   open_left  = '0;   // continuation bytes still due
	logic [CP_W-1:0]    partial_cp = '0;
	logic [CNT_W-1:0]   open_len   = '0;

	logic [BYTE_W-1:0]  text_bytes[$];          // words not yet offered
	cp_word_t           pending_code_points[$]; // predicted, not yet seen
	cp_word_t           want;
	int unsigned        mismatches = 0;

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Feed one accepted byte through the shadow decoder; queue any code point.
	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		int       ones;
		cp_word_t w;
		ones = 0;
		// any byte inside an open sequence is taken as continuation,
		// top bits ignored
		if (open_left != 0) begin
			partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
			open_left  = open_left - 1'b1;
			if (open_left == 0) begin
				w.code_point = partial_cp;
				w.byte_count = open_len;
				pending_code_points.push_back(w);
				partial_cp = '0;
				open_len   = '0;
			end
		end else begin
			while (ones < BYTE_W && b[BYTE_W-1-ones])
				ones++;
			w.byte_count = 3'd1;
			if (ones == 0) begin
				w.code_point = CP_W'(b);              // plain ASCII
				pending_code_points.push_back(w);
			end else if (ones == 1) begin
				w.code_point = CP_W'(b & LOW6);       // stray continuation
				pending_code_points.push_back(w);
			end else if (ones > MAX_SEQ) begin
				w.code_point = CP_W'(b);              // FE / FF pass through raw
				pending_code_points.push_back(w);
			end else begin
				// lead byte: keep the bits below the first zero
				partial_cp = CP_W'(b & (8'h7F >> ones));
				open_left  = CNT_W'(ones - 1);
				open_len   = CNT_W'(ones);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Text generation
	// ------------------------------------------------------------------------
	// Lead byte for an n-byte sequence, then n-1 followers. Broken sequences
	// use arbitrary followers; the decoder swallows them all the same.
	task automatic add_sequence(input int n, input bit broken);
		text_bytes.push_back(8'((8'hFF << (8 - n)) | ($urandom & (8'h7F >> n))));
		repeat (n - 1) begin
			if (broken)
				text_bytes.push_back(8'($urandom_range(0, 255)));
			else
				text_bytes.push_back(CONT | 8'($urandom_range(0, 63)));
		end
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 9);
		// mostly short sequences, long forms still common enough
		if (r < 4)      return 2;
		else if (r < 6) return 3;
		else if (r < 8) return 4;
		else if (r < 9) return 5;
		else            return 6;
	endfunction

	initial begin
		int r;
		// opening: ASCII ends, stray continuations, raw FE/FF, 2/4/5/6 byte
		// forms incl. the largest code point, and a sequence closed by a
		// byte that is not a continuation
		text_bytes = '{8'h00, 8'h7F, 8'h80, 8'hBF, BYTE_FE, BYTE_FF,
			8'hC3, 8'hA9,
			8'hF0, 8'h9F, 8'h98, 8'h80,
			8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
			8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
			8'hC2, 8'hFF};

		while (text_bytes.size() < TEXT_LEN) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				add_sequence(pick_length(), 1'b0);
			else if (r < 70)
				add_sequence(pick_length(), 1'b1);
			else if (r < 82)
				text_bytes.push_back(8'($urandom_range(0, 127)));
			else if (r < 92)
				text_bytes.push_back(CONT | 8'($urandom_range(0, 63)));
			else
				text_bytes.push_back($urandom_range(0, 1) ? BYTE_FE : BYTE_FF);
		end
	end

	// ------------------------------------------------------------------------
	// Reset, sender, receiver, monitor
	// ------------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	logic        in_fire = 1'b0;  // word on in_byte went at the last edge
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	// Sender: bursts of random length, random gaps, some long gapless runs.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
			// hold the word until taken
		end else if (gap_left != 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (text_bytes.size() != 0) begin
			in_valid <= 1'b1;
			in_byte  <= text_bytes.pop_front();
			if (burst_left <= 1) begin
				burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				                                          : $urandom_range(1, 12);
				gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	ready_mode_t   ready_mode    = RDY_ALWAYS;
	int unsigned   ready_phase   = 0;
	logic [15:0]   ready_pattern = 16'hFFFF;

	// Receiver: stall behavior of its own, re-drawn at random intervals.
	always @(negedge clk) begin
		if (ready_phase == 0) begin
			ready_mode    <= ready_mode_t'($urandom_range(0, 3));
			ready_phase   <= $urandom_range(20, 200);
			ready_pattern <= 16'($urandom) | 16'h0001;  // never a full stall
		end else begin
			ready_phase <= ready_phase - 1;
		end
		case (ready_mode)
			RDY_ALWAYS: begin
				out_ready <= 1'b1;
			end
			RDY_COIN: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			RDY_PATTERN: begin
				out_ready <= ready_pattern[ready_phase[3:0]];
			end
			default: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	int unsigned quiet_cycles = 0;

	// Monitor: predict on input handshakes, check on output handshakes.
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			if (in_valid && in_ready)
				decode_byte(in_byte);

			if (out_valid && out_ready) begin
				if (pending_code_points.size() == 0) begin
					flag_mismatch($sformatf("unexpected word cp=%h cnt=%0d",
						code_point, byte_count));
				end else begin
					want = pending_code_points.pop_front();
					if (code_point !== want.code_point)
						flag_mismatch($sformatf("code_point %h, expected %h",
							code_point, want.code_point));
					if (byte_count !== want.byte_count)
						flag_mismatch($sformatf("byte_count %0d, expected %0d",
							byte_count, want.byte_count));
				end
			end

			// watchdog: nothing moving on either channel
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// End of run: all text taken, all code points seen, then a short tail.
	initial begin
		@(posedge arst_n);
		while (text_bytes.size() != 0 || in_valid || pending_code_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
